### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL of the core.
// Define ASSERT_OFF to compile every check away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Concurrent check of a property under an active-low reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that a condition never holds
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### rtl/core/ledm_pkg.sv
// ---------------------------------------------------------------------------
// ledm_pkg
// Types and constants shared by the LED marker renderer core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ledm_pkg;

	localparam int unsigned COLOR_BITS = 24;
	localparam logic [15:0] WORD_ONE   = 16'hFF00;
	localparam logic [15:0] WORD_ZERO  = 16'hF000;

	typedef logic [COLOR_BITS-1:0] color_t;

	// Command codes of the input channel
	typedef enum logic [2:0] {
		CMD_LABEL = 3'd0,
		CMD_TAIL  = 3'd1,
		CMD_GRAD  = 3'd2,
		CMD_PAIR  = 3'd3,
		CMD_NEXT  = 3'd4
	} cmd_t;

	// Render request handed to the painter
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] center;
		logic [7:0] label_length;
		color_t     label_color;
		logic       tail_left;
		logic [7:0] tail_length;
		color_t     tail_color;
	} paint_req_t;

	// Frame write issued by the painter (strip index, not yet range checked)
	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		color_t     data;
	} paint_wr_t;

endpackage

### rtl/core/ledm_ram.sv
// ---------------------------------------------------------------------------
// ledm_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ledm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port, and read port that holds its data until the next read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/core/ledm_div.sv
// ---------------------------------------------------------------------------
// ledm_div
// Restoring divider, 32-bit dividend by 8-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ledm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] quo_q;
	logic [7:0]  rem_q;
	logic [7:0]  div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [8:0]  shifted;
	logic        fits;

	// Shift in the next dividend bit and trial-subtract
	assign shifted = {rem_q, quo_q[31]};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				div_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? 8'(shifted - {1'b0, div_q}) : shifted[7:0];
				quo_q <= {quo_q[30:0], fits};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/core/ledm_paint.sv
// ---------------------------------------------------------------------------
// ledm_paint
// Render sequencer: walks the label span and the tail span one LED a cycle
// and issues frame writes; gradient LEDs go through a multiply and divide.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ledm_paint import ledm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  paint_req_t req,
	output paint_wr_t  wr,
	output logic       done
);

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] last;
		logic [7:0] len;
		color_t     color;
		logic       grad;
	} span_t;

	typedef enum logic [2:0] {
		P_IDLE,
		P_SPAN,
		P_STEP,
		P_MUL,
		P_LOAD,
		P_DIV
	} pstate_t;

	pstate_t     state_q;
	logic        phase_q;
	span_t       cur_q;
	span_t       nxt_q;
	logic [7:0]  idx_q;
	logic [31:0] prod_q;
	paint_wr_t   wr_q;
	logic        done_q;

	logic [7:0]  half_up;
	logic [7:0]  lab_first;
	logic [7:0]  lab_last;
	logic [7:0]  tail_first;
	logic [7:0]  tail_last;
	span_t       span0;
	span_t       span1;
	logic        span_empty;
	logic        last_hit;
	logic [8:0]  weight;
	logic [32:0] prod_full;
	logic        div_done;
	logic [31:0] div_quo;

	// Work out the label and tail geometry, all indices mod 256
	always_comb begin
		half_up    = 8'((9'(req.label_length) + 9'd1) >> 1);
		lab_first  = req.center - half_up + 8'd1;
		lab_last   = req.center + (req.label_length >> 1);
		tail_first = req.tail_left ? (lab_first - req.tail_length) : (lab_last + 8'd1);
		tail_last  = req.tail_left ? (lab_first - 8'd1) : (lab_last + req.tail_length);
		span0      = '{first: lab_first, last: lab_last, len: req.label_length,
			color: req.label_color, grad: 1'b0};
		span1      = '{first: tail_first, last: tail_last, len: req.tail_length,
			color: req.tail_color, grad: (req.cmd == CMD_GRAD)};
		case (req.cmd)
			CMD_PAIR: begin
				span0 = '{first: req.center, last: req.center, len: 8'd1,
					color: req.label_color, grad: 1'b0};
				span1 = '{first: req.center + 8'd1, last: req.center + 8'd1, len: 8'd1,
					color: req.tail_color, grad: 1'b0};
			end
			CMD_LABEL: begin
				span1.len = '0;
			end
			default: begin
			end
		endcase
	end

	// Span status and gradient weight (last - i + 1, up to 256)
	assign span_empty = (cur_q.len == 8'd0) || (cur_q.first > cur_q.last);
	assign last_hit   = (idx_q == cur_q.last);
	assign weight     = 9'(cur_q.last) - 9'(idx_q) + 9'd1;
	assign prod_full  = 33'(cur_q.color) * 33'(weight);

	ledm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == P_LOAD),
		.dividend (prod_q),
		.divisor  (cur_q.len),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer: hold state, advance through spans, issue writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			phase_q <= 1'b0;
			wr_q.en <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			wr_q.en <= 1'b0;
			done_q  <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						cur_q   <= span0;
						nxt_q   <= span1;
						phase_q <= 1'b0;
						state_q <= P_SPAN;
					end
				end
				P_SPAN: begin
					if (span_empty) begin
						if (!phase_q) begin
							cur_q   <= nxt_q;
							phase_q <= 1'b1;
						end else begin
							done_q  <= 1'b1;
							state_q <= P_IDLE;
						end
					end else begin
						idx_q   <= cur_q.first;
						state_q <= cur_q.grad ? P_MUL : P_STEP;
					end
				end
				P_STEP: begin
					wr_q.en   <= 1'b1;
					wr_q.addr <= idx_q;
					wr_q.data <= cur_q.color;
					if (last_hit) begin
						if (!phase_q) begin
							cur_q   <= nxt_q;
							phase_q <= 1'b1;
							state_q <= P_SPAN;
						end else begin
							done_q  <= 1'b1;
							state_q <= P_IDLE;
						end
					end else begin
						idx_q <= idx_q + 8'd1;
					end
				end
				P_MUL: begin
					prod_q  <= prod_full[31:0];
					state_q <= P_LOAD;
				end
				P_LOAD: begin
					state_q <= P_DIV;
				end
				P_DIV: begin
					if (div_done) begin
						wr_q.en   <= 1'b1;
						wr_q.addr <= idx_q;
						wr_q.data <= div_quo[COLOR_BITS-1:0];
						if (last_hit) begin
							if (!phase_q) begin
								cur_q   <= nxt_q;
								phase_q <= 1'b1;
								state_q <= P_SPAN;
							end else begin
								done_q  <= 1'b1;
								state_q <= P_IDLE;
							end
						end else begin
							idx_q   <= idx_q + 8'd1;
							state_q <= P_MUL;
						end
					end
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	assign wr   = wr_q;
	assign done = done_q;

endmodule

### rtl/core/led_strip_marker_renderer_core.sv
// ---------------------------------------------------------------------------
// led_strip_marker_renderer_core
// Frame of packed LED colours in RAM, painted by render commands and read
// out one SPI word per colour bit by next-word commands.
// ---------------------------------------------------------------------------
//  channel   signals                         transfer when
//  cmd       cmd_valid, cmd_stall, fields    cmd_valid && !cmd_stall
//  word      word_valid, word_stall, fields  word_valid && !word_stall
//  cfg       cfg_wr_en, cfg_wr_data          cfg_wr_en
//
// Next word: each command is accepted with a frame RAM read, then the read goes into the
// output register; a full output register holds the read until it drains.
// Render: visits every LED of the label and tail spans, off-strip LEDs
// included; a gradient LED goes through a multiply, divider start, 32
// divider steps and the write.
// Reset: per-LED valid flops clear the frame at once; no clearing pass.
// Commands are taken one at a time; cmd_stall is high while one is at work.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module led_strip_marker_renderer_core import ledm_pkg::*; #(
	parameter int LED_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  position,
	input  logic [7:0]  label_length,
	input  logic [23:0] label_color,
	input  logic        tail_left,
	input  logic [7:0]  tail_length,
	input  logic [23:0] tail_color,
	output logic        word_valid,
	input  logic        word_stall,
	output logic [15:0] spi_word,
	output logic        last_word
);

	localparam int LED_AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PAINT,
		S_READ
	} state_t;

	state_t            state_q;
	logic [7:0]        skip_q;
	logic [LED_COUNT-1:0] valid_q;
	logic [LED_AW-1:0] read_led_q;
	logic [4:0]        read_bit_q;
	logic              readout_done_q;
	logic              rd_vld_q;
	logic              word_valid_q;
	logic [15:0]       spi_word_q;
	logic              last_word_q;

	cmd_t              cmd;
	logic              cmd_acc;
	logic              render_acc;
	logic              read_acc;
	paint_req_t        req;
	paint_wr_t         paint_wr;
	logic              paint_done;
	logic              mem_we;
	logic [LED_AW-1:0] mem_waddr;
	color_t            rd_data;
	color_t            rd_color;
	logic [4:0]        bit_idx;
	logic              out_free;
	logic              last_bit;
	logic              at_last;

	// Decode the accepted command
	assign cmd_stall  = (state_q != S_IDLE);
	assign cmd        = cmd_t'(command);
	assign cmd_acc    = cmd_valid && !cmd_stall;
	assign render_acc = cmd_acc && ((cmd == CMD_LABEL) || (cmd == CMD_TAIL) ||
		(cmd == CMD_GRAD) || (cmd == CMD_PAIR));
	assign read_acc   = cmd_acc && (cmd == CMD_NEXT) && !readout_done_q;

	// Render request, centre taken past the skipped LEDs
	assign req = '{cmd: cmd, center: 8'(skip_q + position), label_length: label_length,
		label_color: label_color, tail_left: tail_left, tail_length: tail_length,
		tail_color: tail_color};

	ledm_paint u_paint (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (render_acc),
		.req    (req),
		.wr     (paint_wr),
		.done   (paint_done)
	);

	// Drop writes beyond the strip
	assign mem_we    = paint_wr.en && ({1'b0, paint_wr.addr} < 9'(LED_COUNT));
	assign mem_waddr = paint_wr.addr[LED_AW-1:0];

	ledm_ram #(
		.WIDTH (COLOR_BITS),
		.DEPTH (LED_COUNT)
	) u_frame (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (paint_wr.data),
		.rd_en   (read_acc),
		.rd_addr (read_led_q),
		.rd_data (rd_data)
	);

	// Skip offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
		end else if (cfg_wr_en) begin
			skip_q <= cfg_wr_data;
		end
	end

	// Per-LED valid flags: clear the whole frame on render, mark painted LEDs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (render_acc) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[mem_waddr] <= 1'b1;
		end
	end

	// Select the colour bit, MSB first
	assign rd_color = rd_vld_q ? rd_data : '0;
	assign bit_idx  = 5'(COLOR_BITS - 1) - read_bit_q;
	assign out_free = !word_valid_q || !word_stall;
	assign last_bit = (read_bit_q == 5'(COLOR_BITS - 1));
	assign at_last  = last_bit && (read_led_q == LED_AW'(LED_COUNT - 1));

	// Control state, readout pointers and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			read_led_q     <= '0;
			read_bit_q     <= '0;
			readout_done_q <= 1'b0;
			rd_vld_q       <= 1'b0;
			word_valid_q   <= 1'b0;
			spi_word_q     <= '0;
			last_word_q    <= 1'b0;
		end else begin
			if (word_valid_q && !word_stall && (state_q != S_READ)) begin
				word_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (render_acc) begin
						read_led_q     <= '0;
						read_bit_q     <= '0;
						readout_done_q <= 1'b0;
						state_q        <= S_PAINT;
					end else if (read_acc) begin
						rd_vld_q <= valid_q[read_led_q];
						state_q  <= S_READ;
					end
				end
				S_PAINT: begin
					if (paint_done) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (out_free) begin
						word_valid_q <= 1'b1;
						spi_word_q   <= rd_color[bit_idx] ? WORD_ONE : WORD_ZERO;
						last_word_q  <= at_last;
						if (at_last) begin
							readout_done_q <= 1'b1;
						end else if (last_bit) begin
							read_bit_q <= '0;
							read_led_q <= read_led_q + LED_AW'(1);
						end else begin
							read_bit_q <= read_bit_q + 5'd1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign word_valid = word_valid_q;
	assign spi_word   = spi_word_q;
	assign last_word  = last_word_q;

	// Frame writes only while a render is in progress
	`ASSERT_PROP(a_wr_in_paint, clk, arst_n, paint_wr.en |-> (state_q == S_PAINT), "frame write outside render")
	// A new word comes only from a frame read
	`ASSERT_PROP(a_word_from_read, clk, arst_n, $rose(word_valid_q) |-> $past(state_q == S_READ), "word without frame read")
	// No read once the frame has been fully emitted
	`ASSERT_NEVER(a_no_read_after_end, clk, arst_n, readout_done_q && (state_q == S_READ), "read after last word")

endmodule
